// ===== src/rcd_pkg.sv =====
// ============================================================================
// rcd_pkg: shared types, constants and microprogram of the Rice decoder
// Holds the control word format, the condition and operation codes, the
// status codes, the configuration register indexes and the sequencer ROM.
// ============================================================================
`default_nettype none

package rcd_pkg;

    // Largest frame length in coefficients; a larger configured count is cut to it.
    localparam int unsigned MAX_COEFFS = 4096;
    // Width that holds any frame length and any coefficient index plus one.
    localparam int unsigned FLEN_W     = 17;
    // Saturation value of the byte counter.
    localparam logic [19:0] COUNT_MAX  = 20'hFFFFF;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_EXHAUST = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RICE_K      = 2'd0;
    localparam logic [1:0] CFG_MAG_BOUND   = 2'd1;
    localparam logic [1:0] CFG_COEFF_COUNT = 2'd2;

    // Field being decoded within one coefficient.
    typedef enum logic [1:0] {
        PH_LOW   = 2'd0,
        PH_UNARY = 2'd1,
        PH_SIGN  = 2'd2
    } t_phase;

    // Datapath operations, one per microinstruction.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_BYTE_START,
        OP_LOW_STEP,
        OP_ONES_INC,
        OP_CALC_MAG,
        OP_SET_SIGN,
        OP_EMIT_COEF,
        OP_EMIT_RANGE,
        OP_EMIT_EXH,
        OP_NEXT_BIT,
        OP_END_FRAME,
        OP_SKIP_BYTE
    } t_op;

    // Branch conditions tested by the sequencer.
    typedef enum logic [3:0] {
        C_TRUE,
        C_IN_ACC,
        C_SKIP,
        C_BIT_ZERO,
        C_ONES_LT,
        C_MAG_GT,
        C_MAG_NZ,
        C_EMIT_ENDS,
        C_LAST_BIT,
        C_FIN,
        C_DISPATCH
    } t_cond;

    typedef logic [4:0] t_uaddr;

    // Microprogram addresses.
    localparam t_uaddr A_IDLE    = 5'd0;
    localparam t_uaddr A_CHKSKIP = 5'd1;
    localparam t_uaddr A_START   = 5'd2;
    localparam t_uaddr A_BIT     = 5'd3;
    localparam t_uaddr A_UNARY   = 5'd4;
    localparam t_uaddr A_ONES    = 5'd5;
    localparam t_uaddr A_FIN     = 5'd6;
    localparam t_uaddr A_CHKMAG  = 5'd7;
    localparam t_uaddr A_CHKZ    = 5'd8;
    localparam t_uaddr A_SETSIGN = 5'd9;
    localparam t_uaddr A_EMITZ   = 5'd10;
    localparam t_uaddr A_SIGN    = 5'd11;
    localparam t_uaddr A_EMITS   = 5'd12;
    localparam t_uaddr A_RANGE   = 5'd13;
    localparam t_uaddr A_NEXT    = 5'd14;
    localparam t_uaddr A_AFTER   = 5'd15;
    localparam t_uaddr A_EXH     = 5'd16;
    localparam t_uaddr A_END     = 5'd17;
    localparam t_uaddr A_SKIP    = 5'd18;

    // One control word: operation, wait for a free output register, branch.
    typedef struct packed {
        t_op    op;
        logic   wait_out;
        t_cond  cond;
        t_uaddr tgt_t;
        t_uaddr tgt_f;
    } t_uword;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic   in_acc;
        logic   skip;
        logic   bit_zero;
        logic   ones_lt;
        logic   mag_gt;
        logic   mag_nz;
        logic   emit_ends;
        logic   last_bit;
        logic   fin;
        logic   out_free;
        t_phase phase;
    } t_flags;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_op  op;
        logic en;
        logic idle;
    } t_ctrl;

    // The microprogram. Each bit of a byte runs through the BIT dispatch and
    // one of the low, unary or sign paths, then NEXT, unless it ends the frame.
    function automatic t_uword ucode_rom(input t_uaddr addr);
        t_uword w;
        case (addr)
            A_IDLE:    w = '{OP_NOP,        1'b0, C_IN_ACC,    A_CHKSKIP, A_IDLE};
            A_CHKSKIP: w = '{OP_NOP,        1'b0, C_SKIP,      A_SKIP,    A_START};
            A_START:   w = '{OP_BYTE_START, 1'b0, C_TRUE,      A_BIT,     A_BIT};
            A_BIT:     w = '{OP_LOW_STEP,   1'b0, C_DISPATCH,  A_NEXT,    A_NEXT};
            A_UNARY:   w = '{OP_NOP,        1'b0, C_BIT_ZERO,  A_FIN,     A_ONES};
            A_ONES:    w = '{OP_ONES_INC,   1'b0, C_ONES_LT,   A_NEXT,    A_FIN};
            A_FIN:     w = '{OP_CALC_MAG,   1'b0, C_TRUE,      A_CHKMAG,  A_CHKMAG};
            A_CHKMAG:  w = '{OP_NOP,        1'b0, C_MAG_GT,    A_RANGE,   A_CHKZ};
            A_CHKZ:    w = '{OP_NOP,        1'b0, C_MAG_NZ,    A_SETSIGN, A_EMITZ};
            A_SETSIGN: w = '{OP_SET_SIGN,   1'b0, C_TRUE,      A_NEXT,    A_NEXT};
            A_EMITZ:   w = '{OP_EMIT_COEF,  1'b1, C_EMIT_ENDS, A_END,     A_NEXT};
            A_SIGN:    w = '{OP_CALC_MAG,   1'b0, C_TRUE,      A_EMITS,   A_EMITS};
            A_EMITS:   w = '{OP_EMIT_COEF,  1'b1, C_EMIT_ENDS, A_END,     A_NEXT};
            A_RANGE:   w = '{OP_EMIT_RANGE, 1'b1, C_TRUE,      A_END,     A_END};
            A_NEXT:    w = '{OP_NEXT_BIT,   1'b0, C_LAST_BIT,  A_AFTER,   A_BIT};
            A_AFTER:   w = '{OP_NOP,        1'b0, C_FIN,       A_EXH,     A_IDLE};
            A_EXH:     w = '{OP_EMIT_EXH,   1'b1, C_TRUE,      A_END,     A_END};
            A_END:     w = '{OP_END_FRAME,  1'b0, C_TRUE,      A_IDLE,    A_IDLE};
            A_SKIP:    w = '{OP_SKIP_BYTE,  1'b0, C_TRUE,      A_IDLE,    A_IDLE};
            default:   w = '{OP_NOP,        1'b0, C_TRUE,      A_IDLE,    A_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/rcd_sequencer.sv =====
// ============================================================================
// rcd_sequencer: microprogram sequencer of the Rice decoder
// Holds the step counter, reads the control word from the ROM, tests the
// selected condition and picks the next step. Emitting steps wait until
// the output register can take a new item.
// ============================================================================
`default_nettype none

module rcd_sequencer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rcd_pkg::t_flags i_flags,
    output rcd_pkg::t_ctrl     o_ctrl
);

    rcd_pkg::t_uaddr r_upc;
    rcd_pkg::t_uaddr n_upc;
    rcd_pkg::t_uword uword;
    logic            cond_hit;
    logic            hold;
    rcd_pkg::t_uaddr dispatch_tgt;

    assign uword = rcd_pkg::ucode_rom(r_upc);

    // A step that emits an item stalls while the output register is full.
    assign hold = uword.wait_out && !i_flags.out_free;

    // Condition select.
    always_comb begin
        case (uword.cond)
            rcd_pkg::C_TRUE:      cond_hit = 1'b1;
            rcd_pkg::C_IN_ACC:    cond_hit = i_flags.in_acc;
            rcd_pkg::C_SKIP:      cond_hit = i_flags.skip;
            rcd_pkg::C_BIT_ZERO:  cond_hit = i_flags.bit_zero;
            rcd_pkg::C_ONES_LT:   cond_hit = i_flags.ones_lt;
            rcd_pkg::C_MAG_GT:    cond_hit = i_flags.mag_gt;
            rcd_pkg::C_MAG_NZ:    cond_hit = i_flags.mag_nz;
            rcd_pkg::C_EMIT_ENDS: cond_hit = i_flags.emit_ends;
            rcd_pkg::C_LAST_BIT:  cond_hit = i_flags.last_bit;
            rcd_pkg::C_FIN:       cond_hit = i_flags.fin;
            default:              cond_hit = 1'b0;
        endcase
    end

    // Dispatch on the field that the current bit belongs to.
    always_comb begin
        case (i_flags.phase)
            rcd_pkg::PH_LOW:   dispatch_tgt = rcd_pkg::A_NEXT;
            rcd_pkg::PH_SIGN:  dispatch_tgt = rcd_pkg::A_SIGN;
            default:           dispatch_tgt = rcd_pkg::A_UNARY;
        endcase
    end

    // Next step.
    always_comb begin
        if (hold) begin
            n_upc = r_upc;
        end else if (uword.cond == rcd_pkg::C_DISPATCH) begin
            n_upc = dispatch_tgt;
        end else if (cond_hit) begin
            n_upc = uword.tgt_t;
        end else begin
            n_upc = uword.tgt_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= rcd_pkg::A_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Control to the datapath.
    always_comb begin
        o_ctrl.op   = uword.op;
        o_ctrl.en   = !hold;
        o_ctrl.idle = (r_upc == rcd_pkg::A_IDLE);
    end

endmodule

`default_nettype wire

// ===== src/rice_coefficient_decoder_core.sv =====
// ============================================================================
// rice_coefficient_decoder_core: signed Golomb-Rice coefficient decoder
// Decodes a packed bit stream, one byte per input item, into signed
// coefficients under a microprogrammed sequencer.
// ============================================================================
//
// Usage:
//   The input channel takes one stream byte per item, with a flag that marks the
//   last byte of the frame's buffer. Bits are used least-significant first. The
//   output channel gives one item per decoded coefficient and one per error; the
//   last item of a frame carries frame_end and the byte count. Configuration
//   registers use their own channel; write them only while idle (not enforced).
// Timing:
//   The sequencer runs one microinstruction per cycle unless an emitting step
//   waits for the output register. Each bit runs through the dispatch and one
//   field path; each byte adds a fetch and a wrap-up. A result item appears
//   in the output register on the cycle after the step that made it.
// Reset:
//   Synchronous reset loads the default register values, starts a new frame
//   and empties the output register.
// Stall:
//   While the receiver stalls and the output register is full, the sequencer
//   halts at its next emitting step; no new byte is taken until the current
//   one is done.
// ============================================================================
`default_nettype none

module rice_coefficient_decoder_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Byte input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_in_byte,
    input  wire logic               i_final_byte,
    // Result output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_coefficient,
    output logic [1:0]              o_status,
    output logic                    o_frame_end,
    output logic [19:0]             o_bytes_used,
    // Configuration write channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [30:0]        i_cfg_data
);

    // Configuration registers.
    logic [4:0]  r_rice_k;
    logic [30:0] r_bound;
    logic [12:0] r_coeff_count;

    // Current byte.
    logic [7:0]  r_byte,   n_byte;
    logic        r_fin,    n_fin;
    logic [2:0]  r_bit_idx, n_bit_idx;
    logic [2:0]  r_nres,   n_nres;

    // Decoder state.
    rcd_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_bit_count,   n_bit_count;
    logic [30:0] r_low,         n_low;
    logic [31:0] r_ones,        n_ones;
    logic [12:0] r_coeff_index, n_coeff_index;
    logic [19:0] r_byte_count,  n_byte_count;
    logic        r_skipping,    n_skipping;
    logic        r_err,         n_err;
    logic [62:0] r_mag,         n_mag;

    // Output register.
    logic        r_out_valid,  n_out_valid;
    logic [31:0] r_out_coef,   n_out_coef;
    logic [1:0]  r_out_status, n_out_status;
    logic        r_out_fe,     n_out_fe;
    logic [19:0] r_out_bytes,  n_out_bytes;

    rcd_pkg::t_flags flags;
    rcd_pkg::t_ctrl  ctrl;

    logic                           in_acc;
    logic                           out_free;
    logic                           cur_bit;
    logic                           low_done;
    rcd_pkg::t_phase                eff_phase;
    logic [32:0]                    max_ones;
    logic [32:0]                    ones_inc;
    logic [rcd_pkg::FLEN_W-1:0]     cnt_min1;
    logic [rcd_pkg::FLEN_W-1:0]     frame_len;
    logic [rcd_pkg::FLEN_W-1:0]     idx_inc;
    logic                           coef_last;
    logic                           coef_replace;
    logic [31:0]                    coef_val;

    // Handshakes.
    assign o_in_stall  = !ctrl.idle;
    assign in_acc      = i_in_valid && ctrl.idle;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Bit under decode and the field it falls in.
    assign cur_bit  = r_byte[r_bit_idx];
    assign low_done = (r_bit_count >= r_rice_k);
    always_comb begin
        if (r_phase == rcd_pkg::PH_LOW && !low_done) begin
            eff_phase = rcd_pkg::PH_LOW;
        end else if (r_phase == rcd_pkg::PH_SIGN) begin
            eff_phase = rcd_pkg::PH_SIGN;
        end else begin
            eff_phase = rcd_pkg::PH_UNARY;
        end
    end

    // Unary run limit: (bound >> k) + 1 ones.
    assign max_ones = {2'b00, r_bound >> r_rice_k} + 33'd1;
    assign ones_inc = {1'b0, r_ones} + 33'd1;

    // Frame length with a zero count taken as one and a cap at the maximum.
    assign cnt_min1  = (r_coeff_count == 13'd0) ? rcd_pkg::FLEN_W'(1)
                                                : rcd_pkg::FLEN_W'(r_coeff_count);
    assign frame_len = (cnt_min1 > rcd_pkg::FLEN_W'(rcd_pkg::MAX_COEFFS))
                       ? rcd_pkg::FLEN_W'(rcd_pkg::MAX_COEFFS) : cnt_min1;
    assign idx_inc   = rcd_pkg::FLEN_W'(r_coeff_index) + rcd_pkg::FLEN_W'(1);
    assign coef_last = (idx_inc >= frame_len);

    // An eighth coefficient from a final byte that does not end the frame
    // gives way to the exhaustion item.
    assign coef_replace = (r_bit_idx == 3'd7) && r_fin && (r_nres == 3'd7) && !coef_last;

    // Signed value; the zero-magnitude path is in the unary field.
    assign coef_val = (r_phase == rcd_pkg::PH_SIGN && cur_bit) ? (32'd0 - r_mag[31:0])
                                                                : r_mag[31:0];

    // Flags for the sequencer.
    always_comb begin
        flags.in_acc    = in_acc;
        flags.skip      = r_skipping;
        flags.bit_zero  = !cur_bit;
        flags.ones_lt   = (ones_inc < max_ones);
        flags.mag_gt    = (|r_mag[62:31]) || (r_mag[30:0] > r_bound);
        flags.mag_nz    = |r_mag;
        flags.emit_ends = coef_last || coef_replace;
        flags.last_bit  = (r_bit_idx == 3'd7);
        flags.fin       = r_fin;
        flags.out_free  = out_free;
        flags.phase     = eff_phase;
    end

    rcd_sequencer u_sequencer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    // Datapath next-state logic driven by the current control word.
    always_comb begin
        n_byte        = r_byte;
        n_fin         = r_fin;
        n_bit_idx     = r_bit_idx;
        n_nres        = r_nres;
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_low         = r_low;
        n_ones        = r_ones;
        n_coeff_index = r_coeff_index;
        n_byte_count  = r_byte_count;
        n_skipping    = r_skipping;
        n_err         = r_err;
        n_mag         = r_mag;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_coef    = r_out_coef;
        n_out_status  = r_out_status;
        n_out_fe      = r_out_fe;
        n_out_bytes   = r_out_bytes;

        // Latch an accepted item.
        if (in_acc) begin
            n_byte = i_in_byte;
            n_fin  = i_final_byte;
        end

        if (ctrl.en) begin
            case (ctrl.op)
                rcd_pkg::OP_BYTE_START: begin
                    if (r_byte_count < rcd_pkg::COUNT_MAX) begin
                        n_byte_count = r_byte_count + 20'd1;
                    end
                    n_bit_idx = 3'd0;
                    n_nres    = 3'd0;
                end
                rcd_pkg::OP_LOW_STEP: begin
                    if (eff_phase == rcd_pkg::PH_LOW) begin
                        n_low[r_bit_count] = cur_bit;
                        n_bit_count        = r_bit_count + 5'd1;
                    end else if (r_phase == rcd_pkg::PH_LOW) begin
                        n_phase = rcd_pkg::PH_UNARY;
                        n_ones  = 32'd0;
                    end
                end
                rcd_pkg::OP_ONES_INC: begin
                    n_ones = ones_inc[31:0];
                end
                rcd_pkg::OP_CALC_MAG: begin
                    n_mag = ({31'd0, r_ones} << r_rice_k) | {32'd0, r_low};
                end
                rcd_pkg::OP_SET_SIGN: begin
                    n_phase = rcd_pkg::PH_SIGN;
                end
                rcd_pkg::OP_EMIT_COEF: begin
                    n_out_valid = 1'b1;
                    if (coef_replace) begin
                        n_out_coef   = 32'd0;
                        n_out_status = rcd_pkg::ST_EXHAUST;
                        n_out_fe     = 1'b1;
                        n_out_bytes  = r_byte_count;
                        n_err        = 1'b1;
                    end else begin
                        n_out_coef   = coef_val;
                        n_out_status = rcd_pkg::ST_OK;
                        n_out_fe     = coef_last;
                        n_out_bytes  = coef_last ? r_byte_count : 20'd0;
                        n_nres        = r_nres + 3'd1;
                        n_coeff_index = r_coeff_index + 13'd1;
                        n_phase       = rcd_pkg::PH_LOW;
                        n_bit_count   = 5'd0;
                        n_low         = 31'd0;
                        n_ones        = 32'd0;
                    end
                end
                rcd_pkg::OP_EMIT_RANGE: begin
                    n_out_valid  = 1'b1;
                    n_out_coef   = 32'd0;
                    n_out_status = rcd_pkg::ST_RANGE;
                    n_out_fe     = 1'b1;
                    n_out_bytes  = r_byte_count;
                    n_err        = 1'b1;
                end
                rcd_pkg::OP_EMIT_EXH: begin
                    n_out_valid  = 1'b1;
                    n_out_coef   = 32'd0;
                    n_out_status = rcd_pkg::ST_EXHAUST;
                    n_out_fe     = 1'b1;
                    n_out_bytes  = r_byte_count;
                    n_err        = 1'b1;
                end
                rcd_pkg::OP_NEXT_BIT: begin
                    n_bit_idx = r_bit_idx + 3'd1;
                end
                rcd_pkg::OP_END_FRAME: begin
                    // An error before the final byte skips the rest of the buffer.
                    if (r_err && !r_fin) begin
                        n_skipping = 1'b1;
                    end
                    n_err         = 1'b0;
                    n_phase       = rcd_pkg::PH_LOW;
                    n_bit_count   = 5'd0;
                    n_low         = 31'd0;
                    n_ones        = 32'd0;
                    n_coeff_index = 13'd0;
                    n_byte_count  = 20'd0;
                end
                rcd_pkg::OP_SKIP_BYTE: begin
                    if (r_fin) begin
                        n_skipping    = 1'b0;
                        n_phase       = rcd_pkg::PH_LOW;
                        n_bit_count   = 5'd0;
                        n_low         = 31'd0;
                        n_ones        = 32'd0;
                        n_coeff_index = 13'd0;
                        n_byte_count  = 20'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control and decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= rcd_pkg::PH_LOW;
            r_bit_count   <= 5'd0;
            r_low         <= 31'd0;
            r_ones        <= 32'd0;
            r_coeff_index <= 13'd0;
            r_byte_count  <= 20'd0;
            r_skipping    <= 1'b0;
            r_err         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_bit_idx     <= 3'd0;
            r_nres        <= 3'd0;
        end else begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_low         <= n_low;
            r_ones        <= n_ones;
            r_coeff_index <= n_coeff_index;
            r_byte_count  <= n_byte_count;
            r_skipping    <= n_skipping;
            r_err         <= n_err;
            r_out_valid   <= n_out_valid;
            r_bit_idx     <= n_bit_idx;
            r_nres        <= n_nres;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_fin        <= n_fin;
        r_mag        <= n_mag;
        r_out_coef   <= n_out_coef;
        r_out_status <= n_out_status;
        r_out_fe     <= n_out_fe;
        r_out_bytes  <= n_out_bytes;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rice_k      <= 5'd0;
            r_bound       <= 31'h7FFFFFFF;
            r_coeff_count <= 13'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rcd_pkg::CFG_RICE_K:      r_rice_k      <= i_cfg_data[4:0];
                rcd_pkg::CFG_MAG_BOUND:   r_bound       <= i_cfg_data;
                rcd_pkg::CFG_COEFF_COUNT: r_coeff_count <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    // Outputs.
    assign o_out_valid   = r_out_valid;
    assign o_coefficient = signed'(r_out_coef);
    assign o_status      = r_out_status;
    assign o_frame_end   = r_out_fe;
    assign o_bytes_used  = r_out_bytes;

endmodule

`default_nettype wire

// ===== src/rcd_checker.sv =====
// ============================================================================
// rcd_checker: port-level checks of the Rice decoder
// Watches the top level's ports for result and handshake rules and is
// attached to every instance of the top level by a bind statement.
// ============================================================================
`default_nettype none

module rcd_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic signed [31:0] o_coefficient,
    input wire logic [1:0]         o_status,
    input wire logic               o_frame_end,
    input wire logic [19:0]        o_bytes_used
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A byte keeps the block busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("new byte taken right after a byte");

    // Error items end the frame and carry a zero coefficient.
    a_error_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != rcd_pkg::ST_OK) |->
        (o_frame_end && o_coefficient == 32'sd0))
        else $error("error item without frame end or with nonzero value");

    // The byte count shows only on the last item of a frame.
    a_bytes_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_end) |-> (o_bytes_used == 20'd0))
        else $error("byte count on an item inside the frame");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_coefficient) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind rice_coefficient_decoder_core rcd_checker u_rcd_checker (.*);

`default_nettype wire

// ===== dv/coeff_stream_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// coeff_stream_checker: result predictor and scoreboard for the Rice decoder
// Watches the byte, result and register channels of the decoder. Every
// accepted byte is decoded here bit by bit into the results it must cause.
// Every accepted result is then compared field by field with the oldest
// expected one.
// ============================================================================

module coeff_stream_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_in_byte,
    input  logic               i_final_byte,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_coefficient,
    input  logic [1:0]         i_status,
    input  logic               i_frame_end,
    input  logic [19:0]        i_bytes_used,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    output int                 o_mismatches,
    output int                 o_pending
);

    // One result item as it leaves the decoder.
    typedef struct packed {
        logic signed [31:0] coef;
        logic [1:0]         status;
        logic               frame_end;
        logic [19:0]        bytes_used;
    } t_result;

    // Ways a byte can leave the frame.
    typedef enum int {
        RUN_ON,
        RUN_DONE,
        RUN_ERROR
    } t_run;

    // Register copies.
    logic [4:0]  cfg_k;
    logic [30:0] cfg_bound;
    logic [12:0] cfg_count;

    // Decoder state as predicted.
    rcd_pkg::t_phase fld_phase;
    logic [4:0]  low_cnt;
    logic [30:0] low_acc;
    logic [31:0] ones_run;
    logic [12:0] coeff_idx;
    logic [19:0] frame_bytes;
    logic        skip_mode;

    // Results of the byte being decoded, and those still awaited.
    t_result     byte_results [0:7];
    int          byte_n;
    t_result     expected_coeffs [$];
    int          fail_cnt;
    t_result     got;
    t_result     want;

    function automatic void clear_coeff();
        fld_phase = rcd_pkg::PH_LOW;
        low_cnt   = '0;
        low_acc   = '0;
        ones_run  = '0;
    endfunction

    function automatic void clear_frame();
        clear_coeff();
        coeff_idx   = '0;
        frame_bytes = '0;
    endfunction

    // A count of zero means one; anything above the limit is cut to it.
    function automatic int unsigned frame_len();
        int unsigned c;
        c = 32'(cfg_count);
        if (c == 0) c = 1;
        if (c > rcd_pkg::MAX_COEFFS) c = rcd_pkg::MAX_COEFFS;
        return c;
    endfunction

    function automatic logic [63:0] magnitude();
        return ({32'd0, ones_run} << cfg_k) | {33'd0, low_acc};
    endfunction

    // Only the last result of a frame reports the byte count.
    function automatic void put_result(input logic [31:0] coef, input logic [1:0] st,
                                       input logic fe);
        byte_results[byte_n] = '{coef, st, fe, fe ? frame_bytes : 20'd0};
        byte_n++;
    endfunction

    // Emits a finished coefficient and tells whether the frame is complete.
    function automatic logic emit_coeff(input logic [31:0] coef);
        logic last;
        coeff_idx++;
        last = (32'(coeff_idx) >= frame_len());
        put_result(coef, rcd_pkg::ST_OK, last);
        clear_coeff();
        return last;
    endfunction

    // Unary run complete: range check, zero value, or on to the sign bit.
    function automatic t_run close_magnitude();
        logic [63:0] mag;
        mag = magnitude();
        if (mag > {33'd0, cfg_bound}) begin
            put_result(32'd0, rcd_pkg::ST_RANGE, 1'b1);
            return RUN_ERROR;
        end
        if (mag == 64'd0) return emit_coeff(32'd0) ? RUN_DONE : RUN_ON;
        fld_phase = rcd_pkg::PH_SIGN;
        return RUN_ON;
    endfunction

    // Decodes one stream byte and queues the results it causes.
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        t_run        ended;
        logic [31:0] maxh;
        logic [63:0] mag;
        logic [63:0] val;
        int          i;
        byte_n = 0;
        ended  = RUN_ON;
        if (skip_mode) begin
            // After an error everything up to and including the final byte is dropped.
            if (fin) begin
                skip_mode = 1'b0;
                clear_frame();
            end
            return;
        end
        if (frame_bytes < rcd_pkg::COUNT_MAX) frame_bytes++;

        for (i = 0; i < 8 && ended == RUN_ON; i++) begin
            if (fld_phase == rcd_pkg::PH_LOW && low_cnt >= cfg_k) begin
                fld_phase = rcd_pkg::PH_UNARY;
                ones_run  = '0;
            end
            if (fld_phase == rcd_pkg::PH_LOW) begin
                low_acc[low_cnt] = low_acc[low_cnt] | b[i];
                low_cnt++;
            end else if (fld_phase == rcd_pkg::PH_UNARY) begin
                if (!b[i]) begin
                    ended = close_magnitude();
                end else begin
                    // The run stops by itself once it can only overflow the bound.
                    maxh = ({1'b0, cfg_bound} >> cfg_k) + 32'd1;
                    ones_run++;
                    if (ones_run >= maxh) ended = close_magnitude();
                end
            end else begin
                mag   = magnitude();
                val   = b[i] ? (64'd0 - mag) : mag;
                ended = emit_coeff(val[31:0]) ? RUN_DONE : RUN_ON;
            end
        end

        // Buffer ran out mid-frame: the error takes the place of an eighth result.
        if (ended == RUN_ON && fin) begin
            if (byte_n >= 8) byte_n = 7;
            put_result(32'd0, rcd_pkg::ST_EXHAUST, 1'b1);
            ended = RUN_ERROR;
        end
        if (ended != RUN_ON) begin
            if (ended == RUN_ERROR && !fin) skip_mode = 1'b1;
            clear_frame();
        end
        for (i = 0; i < byte_n; i++) expected_coeffs.push_back(byte_results[i]);
    endtask

    // Channel monitor: results are checked before new bytes are predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_k     = 5'd0;
            cfg_bound = 31'h7FFFFFFF;
            cfg_count = 13'd256;
            clear_frame();
            skip_mode = 1'b0;
            expected_coeffs.delete();
            fail_cnt  = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_coefficient, i_status, i_frame_end, i_bytes_used};
                if (expected_coeffs.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("%0t: unexpected item: coef %0d status %0d fe %0d bytes %0d",
                                 $realtime, got.coef, got.status, got.frame_end,
                                 got.bytes_used);
                    fail_cnt++;
                end else begin
                    want = expected_coeffs.pop_front();
                    if (got.coef !== want.coef || got.status !== want.status ||
                        got.frame_end !== want.frame_end ||
                        got.bytes_used !== want.bytes_used) begin
                        if (fail_cnt < 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected: coef %0d status %0d fe %0d bytes %0d",
                                     want.coef, want.status, want.frame_end,
                                     want.bytes_used);
                            $display("  actual:   coef %0d status %0d fe %0d bytes %0d",
                                     got.coef, got.status, got.frame_end,
                                     got.bytes_used);
                        end
                        fail_cnt++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rcd_pkg::CFG_RICE_K:      cfg_k = i_cfg_data[4:0];
                    rcd_pkg::CFG_MAG_BOUND:   cfg_bound = i_cfg_data;
                    rcd_pkg::CFG_COEFF_COUNT: cfg_count = i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) decode_byte(i_in_byte, i_final_byte);
        end
        o_mismatches <= fail_cnt;
        o_pending    <= expected_coeffs.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench of the Rice coefficient decoder
// Drives stream bytes and register writes into the decoder under random idle
// and stall patterns, first with hand-picked cases and then with random
// frames. The checker beside the decoder predicts and compares every result.
// ============================================================================

module tb_top;

    // Unassigned register index; writes to it must change nothing.
    localparam logic [1:0]  CFG_SPARE   = 2'd3;
    localparam logic [30:0] BOUND_MAX   = 31'h7FFFFFFF;
    // Wait after the stream stops so that a byte without results can finish.
    localparam int          SETTLE_CYC  = 200;
    localparam int unsigned CYCLE_LIMIT = 500000;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic [7:0]         i_in_byte    = 8'd0;
    logic               i_final_byte = 1'b0;
    logic               i_out_stall  = 1'b0;
    logic               i_cfg_valid  = 1'b0;
    logic [1:0]         i_cfg_index  = rcd_pkg::CFG_RICE_K;
    logic [30:0]        i_cfg_data   = 31'd0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [31:0] o_coefficient;
    logic [1:0]         o_status;
    logic               o_frame_end;
    logic [19:0]        o_bytes_used;
    logic               o_cfg_ready;

    int                 mismatch_cnt;
    int                 pending_cnt;
    int                 send_idle_pct = 38;
    int                 recv_idle_pct = 84;
    int unsigned        cycle_cnt     = 0;

    rice_coefficient_decoder_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_final_byte  (i_final_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_coefficient (o_coefficient),
        .o_status      (o_status),
        .o_frame_end   (o_frame_end),
        .o_bytes_used  (o_bytes_used),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    coeff_stream_checker u_coeff_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_final_byte  (i_final_byte),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_coefficient (o_coefficient),
        .i_status      (o_status),
        .i_frame_end   (o_frame_end),
        .i_bytes_used  (o_bytes_used),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatch_cnt),
        .o_pending     (pending_cnt)
    );

    always #5 i_clk = ~i_clk;

    // Receiver stalls at random at the current rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog against a hung decoder.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Presents one byte after random idle cycles and holds it until taken.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_byte    <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Writes one register and waits until the decoder has taken it.
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stops the byte stream until every expected result has come out;
    // with settle set it also lets a byte without results finish.
    task automatic drain(input logic settle);
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    initial begin
        int          ph;
        int          s;
        int          j;
        int          r;
        logic [7:0]  b;
        logic        fin;
        logic [4:0]  k_val;
        logic [30:0] bound_val;
        logic [12:0] count_val;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: eight zero coefficients per byte, then an exhausted
        // buffer that drops the eighth one, then an unterminated unary run.
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);

        // One-coefficient frames from a zero count; the spare index is ignored.
        drain(1'b1);
        write_reg(rcd_pkg::CFG_COEFF_COUNT, 31'd0);
        write_reg(CFG_SPARE, BOUND_MAX);
        send_byte(8'h06, 1'b0);
        send_byte(8'hB5, 1'b0);

        // Zero bound: a range error, then skipping up to the final byte.
        drain(1'b1);
        write_reg(rcd_pkg::CFG_MAG_BOUND, 31'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h81, 1'b1);
        send_byte(8'h00, 1'b1);

        // Widest low field: first a value over the bound, then the largest value.
        drain(1'b1);
        write_reg(rcd_pkg::CFG_RICE_K, 31'd31);
        write_reg(rcd_pkg::CFG_MAG_BOUND, BOUND_MAX);
        write_reg(rcd_pkg::CFG_COEFF_COUNT, 31'd1);
        repeat (4) send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        repeat (3) send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b1);

        // Count above the limit, and rice_k cut below the low bits gathered.
        drain(1'b1);
        write_reg(rcd_pkg::CFG_COEFF_COUNT, 31'd8191);
        write_reg(rcd_pkg::CFG_RICE_K, 31'd12);
        send_byte(8'hA5, 1'b0);
        drain(1'b1);
        write_reg(rcd_pkg::CFG_RICE_K, 31'd4);
        send_byte(8'h3C, 1'b1);

        drain(1'b1);
        write_reg(rcd_pkg::CFG_COEFF_COUNT, 31'd4096);
        write_reg(rcd_pkg::CFG_RICE_K, 31'd1);
        send_byte(8'h5A, 1'b1);

        // Random frames under three idle patterns, three settings each.
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 38; recv_idle_pct = 84; end
                1: begin send_idle_pct = 84; recv_idle_pct = 38; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (s = 0; s < 3; s++) begin
                drain(1'b1);
                r = $urandom_range(0, 9);
                if (r < 6)       k_val = 5'($urandom_range(0, 3));
                else if (r < 8)  k_val = 5'($urandom_range(4, 31));
                else if (r == 8) k_val = 5'd0;
                else             k_val = 5'd31;
                r = $urandom_range(0, 9);
                if (r < 5)       bound_val = BOUND_MAX;
                else if (r < 7)  bound_val = 31'($urandom_range(0, 200));
                else if (r == 7) bound_val = 31'd0;
                else             bound_val = 31'($urandom());
                r = $urandom_range(0, 9);
                if (r < 7)       count_val = 13'($urandom_range(1, 10));
                else if (r == 7) count_val = 13'd0;
                else if (r == 8) count_val = 13'd4096;
                else             count_val = 13'($urandom_range(4097, 8191));
                write_reg(rcd_pkg::CFG_RICE_K, {26'd0, k_val});
                write_reg(rcd_pkg::CFG_MAG_BOUND, bound_val);
                write_reg(rcd_pkg::CFG_COEFF_COUNT, {18'd0, count_val});

                for (j = 0; j < 10; j++) begin
                    r = $urandom_range(0, 9);
                    if (r == 0)      b = 8'h00;
                    else if (r == 1) b = 8'hFF;
                    else             b = 8'($urandom_range(0, 255));
                    fin = ($urandom_range(0, 3) == 0) ||
                          (j == 9 && $urandom_range(0, 1) == 1);
                    send_byte(b, fin);
                    if ($urandom_range(0, 19) == 0) drain(1'b0);
                end
            end
        end

        drain(1'b1);
        if (mismatch_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
